// ----- design/ts_pkg.sv -----
// Package for the timestamp event scheduler: opcodes, queue command and
// stored entry types, default capacity. No dependencies.
package ts_pkg;

  localparam int CAPACITY_DEF = 64;

  localparam logic [1:0] OPC_PUT   = 2'd0;
  localparam logic [1:0] OPC_GET   = 2'd1;
  localparam logic [1:0] OPC_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    OP_PUT,
    OP_GET,
    OP_CLEAR,
    OP_NOP
  } ts_op_e;

  typedef struct packed {
    ts_op_e      op;
    logic [63:0] time_key;
    logic [15:0] tag;
    logic [7:0]  voice;
    logic [31:0] handle;
  } ts_cmd_t;

  typedef struct packed {
    logic [63:0] ev_time;
    logic [15:0] tag;
    logic [7:0]  voice;
    logic [31:0] handle;
    logic [31:0] id;
  } ts_ent_t;

endpackage

// ----- design/ts_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ts_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/ts_fe.sv -----
// Front end: accepts beats, decodes the opcode and holds commands in a
// two-entry queue for the back end. Depends on ts_pkg.
module ts_fe
  import ts_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [63:0] time_key_i,
  input  logic [15:0] tag_i,
  input  logic [7:0]  voice_i,
  input  logic [31:0] handle_i,
  output logic        cmd_valid_o,
  output ts_cmd_t     cmd_o,
  input  logic        cmd_pop_i
);

  ts_cmd_t    q_q [2];
  ts_cmd_t    q_d [2];
  logic [1:0] cnt_q, cnt_d;
  ts_cmd_t    dec;
  logic       push;
  logic       pop;

  always_comb begin
    dec.time_key = time_key_i;
    dec.tag      = tag_i;
    dec.voice    = voice_i;
    dec.handle   = handle_i;
    unique case (opcode_i)
      OPC_PUT:   dec.op = OP_PUT;
      OPC_GET:   dec.op = OP_GET;
      OPC_CLEAR: dec.op = OP_CLEAR;
      default:   dec.op = OP_NOP;
    endcase
  end

  assign in_stall_o  = (cnt_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign pop         = cmd_pop_i && (cnt_q != 2'd0);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_q[0];

  always_comb begin
    q_d[0] = q_q[0];
    q_d[1] = q_q[1];
    if (pop) begin
      q_d[0] = q_q[1];
    end
    cnt_d = cnt_q - {1'b0, pop} + {1'b0, push};
    if (push) begin
      if ((cnt_q - {1'b0, pop}) == 2'd0) begin
        q_d[0] = dec;
      end else begin
        q_d[1] = dec;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q[0] <= q_d[0];
    q_q[1] <= q_d[1];
  end

endmodule

// ----- design/ts_be.sv -----
// Back end: pending FIFO and arrival-ordered store in RAM, drain, minimum
// scan and compaction sequencer, result register. Depends on ts_pkg, ts_ram.
module ts_be
  import ts_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  input  ts_cmd_t     cmd_i,
  output logic        cmd_pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        ok_o,
  output logic [63:0] event_time_o,
  output logic [31:0] event_id_o,
  output logic [15:0] event_tag_o,
  output logic [7:0]  event_voice_o,
  output logic [31:0] event_handle_o,
  output logic [6:0]  occupancy_o
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int EW = $bits(ts_ent_t);
  localparam logic [CW-1:0] PendMax = CW'(CAPACITY - 1);
  localparam logic [CW-1:0] OrdMax  = CW'(CAPACITY);
  localparam logic [CW-1:0] One     = CW'(1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DRD  = 3'd1;
  localparam logic [2:0] S_DWR  = 3'd2;
  localparam logic [2:0] S_SRD  = 3'd3;
  localparam logic [2:0] S_SCMP = 3'd4;
  localparam logic [2:0] S_CRD  = 3'd5;
  localparam logic [2:0] S_CWR  = 3'd6;
  localparam logic [2:0] S_RESP = 3'd7;

  logic [2:0]    st_q, st_d;
  logic [CW-1:0] pcnt_q, pcnt_d, ocnt_q, ocnt_d, idx_q, idx_d, bidx_q, bidx_d;
  logic [31:0]   nid_q, nid_d;
  logic [63:0]   lim_q, lim_d;
  ts_ent_t       best_q, best_d, res_ent_q, res_ent_d, out_ent_q, out_ent_d;
  logic          res_ok_q, res_ok_d, out_ok_q, out_ok_d, oval_q, oval_d;
  logic [6:0]    out_occ_q, out_occ_d;
  logic [CW:0]   occ_sum;

  logic          p_we, p_re, o_we, o_re;
  logic [AW-1:0] p_waddr, p_raddr, o_waddr, o_raddr;
  ts_ent_t       p_wdata, o_wdata, p_rdata, o_rdata;
  logic [EW-1:0] p_rvec, o_rvec;
  ts_ent_t       cand;
  logic          take;
  logic [CW-1:0] cand_idx;

  ts_ram #(.Width(EW), .Depth(CAPACITY)) u_pend (
    .clk_i, .we_i(p_we), .waddr_i(p_waddr), .wdata_i(p_wdata),
    .re_i(p_re), .raddr_i(p_raddr), .rdata_o(p_rvec)
  );

  ts_ram #(.Width(EW), .Depth(CAPACITY)) u_ord (
    .clk_i, .we_i(o_we), .waddr_i(o_waddr), .wdata_i(o_wdata),
    .re_i(o_re), .raddr_i(o_raddr), .rdata_o(o_rvec)
  );

  assign p_rdata = ts_ent_t'(p_rvec);
  assign o_rdata = ts_ent_t'(o_rvec);

  // running minimum; strict compare keeps the earliest arrival on ties
  assign take     = (idx_q == '0) || (o_rdata.ev_time < best_q.ev_time);
  assign cand     = take ? o_rdata : best_q;
  assign cand_idx = take ? idx_q : bidx_q;
  assign occ_sum  = {1'b0, pcnt_q} + {1'b0, ocnt_q};

  always_comb begin
    st_d      = st_q;
    pcnt_d    = pcnt_q;
    ocnt_d    = ocnt_q;
    idx_d     = idx_q;
    bidx_d    = bidx_q;
    nid_d     = nid_q;
    lim_d     = lim_q;
    best_d    = best_q;
    res_ok_d  = res_ok_q;
    res_ent_d = res_ent_q;
    out_ok_d  = out_ok_q;
    out_ent_d = out_ent_q;
    out_occ_d = out_occ_q;
    oval_d    = oval_q && out_stall_i;
    cmd_pop_o = 1'b0;
    p_we      = 1'b0;
    p_waddr   = pcnt_q[AW-1:0];
    p_wdata   = '0;
    p_re      = 1'b0;
    p_raddr   = idx_q[AW-1:0];
    o_we      = 1'b0;
    o_waddr   = ocnt_q[AW-1:0];
    o_wdata   = p_rdata;
    o_re      = 1'b0;
    o_raddr   = idx_q[AW-1:0];

    unique case (st_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          res_ok_d  = 1'b0;
          res_ent_d = '0;
          lim_d     = cmd_i.time_key;
          st_d      = S_RESP;
          unique case (cmd_i.op)
            OP_PUT: begin
              if (pcnt_q < PendMax) begin
                p_we            = 1'b1;
                p_wdata.ev_time = cmd_i.time_key;
                p_wdata.tag     = cmd_i.tag;
                p_wdata.voice   = cmd_i.voice;
                p_wdata.handle  = cmd_i.handle;
                p_wdata.id      = nid_q;
                pcnt_d          = pcnt_q + One;
                nid_d           = nid_q + 32'd1;
                res_ok_d        = 1'b1;
                res_ent_d.id    = nid_q;
              end
            end
            OP_GET: begin
              idx_d = '0;
              st_d  = S_DRD;
            end
            OP_CLEAR: begin
              pcnt_d = '0;
              ocnt_d = '0;
            end
            default: ;
          endcase
        end
      end
      S_DRD: begin
        if (idx_q >= pcnt_q || ocnt_q == OrdMax) begin
          // rest of the pending FIFO is dropped when the store is full
          pcnt_d = '0;
          idx_d  = '0;
          st_d   = (ocnt_q == '0) ? S_RESP : S_SRD;
        end else begin
          p_re = 1'b1;
          st_d = S_DWR;
        end
      end
      S_DWR: begin
        o_we   = 1'b1;
        ocnt_d = ocnt_q + One;
        idx_d  = idx_q + One;
        st_d   = S_DRD;
      end
      S_SRD: begin
        o_re = 1'b1;
        st_d = S_SCMP;
      end
      S_SCMP: begin
        best_d = cand;
        bidx_d = cand_idx;
        idx_d  = idx_q + One;
        st_d   = S_SRD;
        if (idx_q + One == ocnt_q) begin
          if (cand.ev_time <= lim_q) begin
            res_ok_d  = 1'b1;
            res_ent_d = cand;
            idx_d     = cand_idx;
            st_d      = S_CRD;
          end else begin
            st_d = S_RESP;
          end
        end
      end
      S_CRD: begin
        if (idx_q + One < ocnt_q) begin
          o_re    = 1'b1;
          o_raddr = idx_q[AW-1:0] + AW'(1);
          st_d    = S_CWR;
        end else begin
          ocnt_d = ocnt_q - One;
          st_d   = S_RESP;
        end
      end
      S_CWR: begin
        o_we    = 1'b1;
        o_waddr = idx_q[AW-1:0];
        o_wdata = o_rdata;
        idx_d   = idx_q + One;
        st_d    = S_CRD;
      end
      S_RESP: begin
        if (!oval_q || !out_stall_i) begin
          oval_d    = 1'b1;
          out_ok_d  = res_ok_q;
          out_ent_d = res_ent_q;
          out_occ_d = 7'(occ_sum);
          st_d      = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      pcnt_q <= '0;
      ocnt_q <= '0;
      nid_q  <= '0;
      oval_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      pcnt_q <= pcnt_d;
      ocnt_q <= ocnt_d;
      nid_q  <= nid_d;
      oval_q <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    bidx_q    <= bidx_d;
    lim_q     <= lim_d;
    best_q    <= best_d;
    res_ok_q  <= res_ok_d;
    res_ent_q <= res_ent_d;
    out_ok_q  <= out_ok_d;
    out_ent_q <= out_ent_d;
    out_occ_q <= out_occ_d;
  end

  assign out_valid_o    = oval_q;
  assign ok_o           = out_ok_q;
  assign event_time_o   = out_ent_q.ev_time;
  assign event_id_o     = out_ent_q.id;
  assign event_tag_o    = out_ent_q.tag;
  assign event_voice_o  = out_ent_q.voice;
  assign event_handle_o = out_ent_q.handle;
  assign occupancy_o    = out_occ_q;

endmodule

// ----- design/timestamp_event_scheduler.sv -----
// A put, clear or nop goes from the command queue straight to the back-end result
// state; a get first moves the pending entries into the store, then scans the
// store for the earliest due event and, when a slot is delivered, compacts the slots after it.
// Throughput: one command at a time in the back-end sequencer; the two-deep
// command queue keeps accepting while the back end works, until it is full.
// Reset: asynchronous, active low; FIFO and store become empty, next id 0.
module timestamp_event_scheduler
  import ts_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [63:0] time_key_i,
  input  logic [15:0] tag_i,
  input  logic [7:0]  voice_i,
  input  logic [31:0] handle_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        ok_o,
  output logic [63:0] event_time_o,
  output logic [31:0] event_id_o,
  output logic [15:0] event_tag_o,
  output logic [7:0]  event_voice_o,
  output logic [31:0] event_handle_o,
  output logic [6:0]  occupancy_o
);

  // decoded command beats between front and back
  ts_cmd_t cmd;
  logic    cmd_valid;
  logic    cmd_pop;

  ts_fe u_fe (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .opcode_i, .time_key_i, .tag_i, .voice_i, .handle_i,
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_pop_i(cmd_pop)
  );

  // back end: pending FIFO and store, each a RAM; store is kept in
  // arrival order, the earliest due event is found by a linear scan
  ts_be #(.CAPACITY(CAPACITY)) u_be (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_pop_o(cmd_pop),
    .out_valid_o, .out_stall_i, .ok_o, .event_time_o, .event_id_o,
    .event_tag_o, .event_voice_o, .event_handle_o, .occupancy_o
  );

endmodule

// ----- design/ts_chk.sv -----
// Port-level checker for timestamp_event_scheduler, bound to the top level.
// No dependencies.
module ts_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [1:0]  opcode_i,
  input logic [63:0] time_key_i,
  input logic [15:0] tag_i,
  input logic [7:0]  voice_i,
  input logic [31:0] handle_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        ok_o,
  input logic [63:0] event_time_o,
  input logic [31:0] event_id_o,
  input logic [15:0] event_tag_o,
  input logic [7:0]  event_voice_o,
  input logic [31:0] event_handle_o,
  input logic [6:0]  occupancy_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(event_time_o) && $stable(ok_o)
      && $stable(occupancy_o))
    else $error("stalled result changed");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |-> event_time_o == 64'd0 && event_tag_o == 16'd0
      && event_voice_o == 8'd0 && event_handle_o == 32'd0)
    else $error("refused beat carries event fields");

  a_rst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid out of reset");

endmodule

bind timestamp_event_scheduler ts_chk u_ts_chk (.*);

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for timestamp_event_scheduler: directed table, fill test,
// then random put/get/clear/nop traffic with bursty sender and stalling receiver.
// Depends on ts_pkg and the scheduler RTL.
module testbench
  import ts_pkg::*;
;

  localparam int CAP = CAPACITY_DEF;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int N_RANDOM = 1794;

  typedef struct packed {
    logic        ok;
    logic [63:0] ev_time;
    logic [31:0] id;
    logic [15:0] tag;
    logic [7:0]  voice;
    logic [31:0] handle;
    logic [6:0]  occ;
  } sched_result_t;

  // Directed row; chk means the typed-in result is compared as well.
  typedef struct {
    ts_op_e        op;
    logic [63:0]   tkey;
    logic [15:0]   tag;
    logic [7:0]    voice;
    logic [31:0]   handle;
    bit            chk;
    sched_result_t res;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  opcode_i = OPC_CLEAR;
  logic [63:0] time_key_i = '0;
  logic [15:0] tag_i = '0;
  logic [7:0]  voice_i = '0;
  logic [31:0] handle_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        ok_o;
  logic [63:0] event_time_o;
  logic [31:0] event_id_o;
  logic [15:0] event_tag_o;
  logic [7:0]  event_voice_o;
  logic [31:0] event_handle_o;
  logic [6:0]  occupancy_o;

  timestamp_event_scheduler i_dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Shadow scheduler state.
  ts_ent_t       fifo_q[$];
  ts_ent_t       store_q[$];
  logic [31:0]   next_id;
  sched_result_t expected_q[$];
  // Per-beat typed-in result, when the table gives one.
  bit            typed_chk_q[$];
  sched_result_t typed_res_q[$];

  int  errors = 0;
  int  idle_cycles = 0;
  bit  hold_off = 0;

  function automatic sched_result_t schedule_beat(ts_op_e op, logic [63:0] tk,
      logic [15:0] tg, logic [7:0] vc, logic [31:0] hd);
    sched_result_t r;
    ts_ent_t e;
    int pos;
    r = '0;
    case (op)
      OP_PUT: begin
        if (fifo_q.size() < CAP - 1) begin
          e = '{ev_time: tk, tag: tg, voice: vc, handle: hd, id: next_id};
          fifo_q.push_back(e);
          r.ok = 1'b1;
          r.id = next_id;
          next_id++;
        end
      end
      OP_GET: begin
        // Drain the FIFO in arrival order; stable insert after equal times.
        foreach (fifo_q[i]) begin
          if (store_q.size() < CAP) begin
            pos = 0;
            while (pos < store_q.size() && store_q[pos].ev_time <= fifo_q[i].ev_time)
              pos++;
            store_q.insert(pos, fifo_q[i]);
          end
        end
        fifo_q.delete();
        if (store_q.size() > 0 && store_q[0].ev_time <= tk) begin
          e = store_q.pop_front();
          r.ok = 1'b1;
          r.ev_time = e.ev_time;
          r.id = e.id;
          r.tag = e.tag;
          r.voice = e.voice;
          r.handle = e.handle;
        end
      end
      OP_CLEAR: begin
        fifo_q.delete();
        store_q.delete();
      end
      default: ;
    endcase
    r.occ = 7'(fifo_q.size() + store_q.size());
    return r;
  endfunction

  // Input monitor: predict on every accepted beat.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o)
      expected_q.push_back(schedule_beat(ts_op_e'(opcode_i), time_key_i, tag_i,
                                         voice_i, handle_i));
  end

  // Output checker.
  always @(posedge clk_i) begin
    sched_result_t got, exp_r;
    bit tchk;
    sched_result_t tres;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{ok_o, event_time_o, event_id_o, event_tag_o, event_voice_o,
              event_handle_o, occupancy_o};
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected result %h", got);
      end else begin
        exp_r = expected_q.pop_front();
        tchk = 0;
        if (typed_chk_q.size() > 0) begin
          tchk = typed_chk_q.pop_front();
          tres = typed_res_q.pop_front();
        end
        if (got !== exp_r || (tchk && got !== tres)) begin
          errors++;
          if (errors <= 10)
            $display("ERROR: exp ok=%0b t=%h id=%h tag=%h v=%h h=%h occ=%0d",
                     exp_r.ok, exp_r.ev_time, exp_r.id, exp_r.tag, exp_r.voice,
                     exp_r.handle, exp_r.occ,
                     " | got ok=%0b t=%h id=%h tag=%h v=%h h=%h occ=%0d",
                     got.ok, got.ev_time, got.id, got.tag,
                     got.voice, got.handle, got.occ);
        end
      end
    end
  end

  // Receiver: own stall pattern, plus one long hold-off.
  always @(posedge clk_i) begin
    if (hold_off) out_stall_i <= 1'b1;
    else case ($urandom_range(0, 3))
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      default: out_stall_i <= out_stall_i ^ ($urandom_range(0, 4) == 0);
    endcase
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles <= 0;
    else if (rst_ni)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Offer one beat, hold it until accepted; random gap rules in between.
  int burst_left = 0;
  task automatic send_beat(ts_op_e op, logic [63:0] tk, logic [15:0] tg,
                           logic [7:0] vc, logic [31:0] hd);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
      burst_left = $urandom_range(1, 30);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    opcode_i <= op;
    time_key_i <= tk;
    tag_i <= tg;
    voice_i <= vc;
    handle_i <= hd;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  function automatic logic [63:0] rand_time(int mode);
    case (mode)
      0: return {$urandom, $urandom};
      1: return 64'($urandom_range(0, 15));
      default: return 64'($urandom_range(0, 400));
    endcase
  endfunction

  stim_row_t table_rows[$];
  initial begin
    localparam logic [63:0] TMAX = '1;
    sched_result_t z;
    ts_op_e op;
    int mode;
    next_id = '0;
    z = '0;
    // Directed table.
    table_rows = '{
      '{OP_GET,   TMAX, 16'h0, 8'h0, 32'h0, 1, '{0, 64'h0, 32'h0, 16'h0, 8'h0, 32'h0, 7'd0}},
      '{OP_PUT,   TMAX, 16'hFFFF, 8'hFF, 32'hFFFFFFFF, 1,
        '{1, 64'h0, 32'h0, 16'h0, 8'h0, 32'h0, 7'd1}},
      '{OP_PUT,   64'h0, 16'h0, 8'h0, 32'h0, 1, '{1, 64'h0, 32'h1, 16'h0, 8'h0, 32'h0, 7'd2}},
      '{OP_PUT,   64'd5, 16'h1234, 8'h56, 32'h789ABCDE, 0, z},
      '{OP_PUT,   64'd5, 16'hAAAA, 8'h55, 32'h5555AAAA, 0, z},
      '{OP_NOP,   64'd7, 16'h1, 8'h1, 32'h1, 1, '{0, 64'h0, 32'h0, 16'h0, 8'h0, 32'h0, 7'd4}},
      '{OP_GET,   64'h0, 16'h0, 8'h0, 32'h0, 1, '{1, 64'h0, 32'h1, 16'h0, 8'h0, 32'h0, 7'd3}},
      '{OP_GET,   64'd4, 16'h0, 8'h0, 32'h0, 1, '{0, 64'h0, 32'h0, 16'h0, 8'h0, 32'h0, 7'd3}},
      '{OP_GET,   64'd5, 16'h0, 8'h0, 32'h0, 0, z},
      '{OP_GET,   64'd5, 16'h0, 8'h0, 32'h0, 0, z},
      '{OP_GET,   TMAX - 1, 16'h0, 8'h0, 32'h0, 0, z},
      '{OP_GET,   TMAX, 16'h0, 8'h0, 32'h0, 0, z},
      '{OP_PUT,   64'd9, 16'h0F0F, 8'hF0, 32'h0F0F0F0F, 0, z},
      '{OP_CLEAR, TMAX, 16'hFFFF, 8'hFF, 32'hFFFFFFFF, 1,
        '{0, 64'h0, 32'h0, 16'h0, 8'h0, 32'h0, 7'd0}},
      '{OP_GET,   TMAX, 16'h0, 8'h0, 32'h0, 1, '{0, 64'h0, 32'h0, 16'h0, 8'h0, 32'h0, 7'd0}}
    };
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (table_rows[i]) begin
      typed_chk_q.push_back(table_rows[i].chk);
      typed_res_q.push_back(table_rows[i].res);
      send_beat(table_rows[i].op, table_rows[i].tkey, table_rows[i].tag,
                table_rows[i].voice, table_rows[i].handle);
    end
    // Full FIFO, then full store with drops: 70 puts, one get, 69 more puts.
    for (int k = 0; k < 140; k++) begin
      if (k == 70) send_beat(OP_GET, 64'd0, '0, '0, '0);
      else send_beat(OP_PUT, rand_time(2), 16'($urandom), 8'($urandom), $urandom);
    end
    send_beat(OP_GET, TMAX, '0, '0, '0);
    // Long receiver hold-off while the sender keeps offering.
    fork
      begin
        hold_off = 1;
        repeat (300) @(posedge clk_i);
        hold_off = 0;
      end
    join_none
    // Random traffic: mostly puts and gets, time range mode picked anew every 200 beats.
    mode = 1;
    for (int k = 0; k < N_RANDOM; k++) begin
      if (k % 200 == 0) mode = $urandom_range(0, 2);
      case ($urandom_range(0, 99)) inside
        [0:54]:  op = OP_PUT;
        [55:93]: op = OP_GET;
        [94:96]: op = OP_CLEAR;
        default: op = OP_NOP;
      endcase
      send_beat(op, rand_time(mode), 16'($urandom), 8'($urandom), $urandom);
    end
    in_valid_i <= 1'b0;
    while (expected_q.size() > 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/ts_pkg.sv
design/ts_ram.sv
design/ts_fe.sv
design/ts_be.sv
design/timestamp_event_scheduler.sv
design/ts_chk.sv
verif/testbench.sv
